// ----- hw/rtl/thtmp_pkg.sv -----
`timescale 1ns / 1ps

package thtmp_pkg;

    // Fixed table and arithmetic widths
    localparam int C_NPOINTS  = 25;
    localparam int C_LAST_SEG = C_NPOINTS - 2;
    localparam int C_RES_W    = 21;   // resistance in 0.1 ohm, up to the cold end
    localparam int C_IDX_W    = 5;
    localparam int C_DEN_W    = 19;   // widest segment span
    localparam int C_X_W      = 28;   // step times resistance offset into a segment
    localparam int C_Q_W      = 9;    // fraction of a step, 0..500
    localparam int C_TEMP_W   = 15;
    localparam int C_STEP     = 500;
    localparam int C_COLD     = -2000;
    localparam int C_HOT      = 10000;
    localparam int C_R_OFFSET = 100000;

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIV,
        L_RANGE,
        L_SCAN,
        L_SETUP,
        L_FRAC,
        L_FIN,
        L_DONE
    } t_lane_state;

    // Lane status toward the merge stage
    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [C_TEMP_W-1:0] temp;
    } t_lane_stat;

    // Thermistor resistance at each 5 C point, -20 C first, in 0.1 ohm
    function automatic logic [C_RES_W-1:0] res_at(input logic [C_IDX_W-1:0] idx);
        logic [C_RES_W-1:0] v;
        case (idx)
            5'd0:    v = 21'd1146600;
            5'd1:    v = 21'd845100;
            5'd2:    v = 21'd629270;
            5'd3:    v = 21'd470770;
            5'd4:    v = 21'd355630;
            5'd5:    v = 21'd271190;
            5'd6:    v = 21'd208600;
            5'd7:    v = 21'd162040;
            5'd8:    v = 21'd126830;
            5'd9:    v = 21'd100000;
            5'd10:   v = 21'd79420;
            5'd11:   v = 21'd63270;
            5'd12:   v = 21'd50740;
            5'd13:   v = 21'd41030;
            5'd14:   v = 21'd33360;
            5'd15:   v = 21'd27240;
            5'd16:   v = 21'd22370;
            5'd17:   v = 21'd18460;
            5'd18:   v = 21'd15300;
            5'd19:   v = 21'd12750;
            5'd20:   v = 21'd10680;
            5'd21:   v = 21'd8993;
            5'd22:   v = 21'd7607;
            5'd23:   v = 21'd6452;
            5'd24:   v = 21'd5494;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/thermistor_adc_to_temperature.sv -----
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     i_valid / o_stall    i_sample_first, i_sample_second (ADC_BITS each)
// output    o_valid / i_stall    o_temp_first, o_temp_second (15 bit signed, 0.01 C)
//
// Two lanes convert the samples side by side. After each accept, each lane runs
// a bit-serial divide, a range check, a table walk of up to 24 steps, a setup
// step, the nine-step segment fraction, rounding and a hand-over to the output.
// Input is stalled while either lane works; the next beat can be accepted in
// the same cycle that o_valid rises.
// A zero sample skips the divide; a reading beyond the table ends stops after it.
// Reset is synchronous, active low, and returns both lanes and the output to idle.
// A new beat is taken while a finished result waits under output stall.

module thermistor_adc_to_temperature
    import thtmp_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ADC_BITS-1:0]         i_sample_first,
    input  logic [ADC_BITS-1:0]         i_sample_second,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [C_TEMP_W-1:0]  o_temp_first,
    output logic signed [C_TEMP_W-1:0]  o_temp_second
);

    t_lane_stat w_first;
    t_lane_stat w_second;
    logic       w_start;
    logic       w_ack;

    // Stall input while either lane is working
    assign o_stall = w_first.busy || w_second.busy;
    assign w_start = i_valid && !o_stall;

    thtmp_lane #(
        .ADC_BITS (ADC_BITS)
    ) u_lane_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_sample (i_sample_first),
        .i_ack    (w_ack),
        .o_stat   (w_first)
    );

    thtmp_lane #(
        .ADC_BITS (ADC_BITS)
    ) u_lane_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_sample (i_sample_second),
        .i_ack    (w_ack),
        .o_stat   (w_second)
    );

    thtmp_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_first       (w_first),
        .i_second      (w_second),
        .i_stall       (i_stall),
        .o_ack         (w_ack),
        .o_valid       (o_valid),
        .o_temp_first  (o_temp_first),
        .o_temp_second (o_temp_second)
    );

endmodule

// ----- hw/rtl/thtmp_lane.sv -----
`timescale 1ns / 1ps

module thtmp_lane
    import thtmp_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ADC_BITS-1:0] i_sample,
    input  logic                i_ack,
    output t_lane_stat          o_stat
);

    localparam int DW = ADC_BITS + 17;
    localparam int CW = $clog2(DW);
    localparam logic [DW-1:0] C_DIVIDEND =
        DW'(64'(C_R_OFFSET) * ((64'(1) << ADC_BITS) - 64'(1)));

    t_lane_state                 r_state, n_state;
    logic [ADC_BITS-1:0]         r_div, n_div;
    logic [ADC_BITS:0]           r_rem, n_rem;
    logic [DW-1:0]               r_quo, n_quo;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [C_RES_W-1:0]          r_res, n_res;
    logic [C_IDX_W-1:0]          r_idx, n_idx;
    logic [C_DEN_W-1:0]          r_den, n_den;
    logic [C_X_W-1:0]            r_x, n_x;
    logic [C_Q_W-1:0]            r_q, n_q;
    logic signed [C_TEMP_W-1:0]  r_temp, n_temp;

    logic [ADC_BITS:0]           w_trial;
    logic                        w_div_ge;
    logic [DW-1:0]               w_diff;
    logic [C_X_W-1:0]            w_shift;
    logic signed [15:0]          w_base;
    logic signed [15:0]          w_sum;

    // Shared datapath terms
    always_comb begin
        w_trial  = {r_rem[ADC_BITS-1:0], C_DIVIDEND[r_cnt]};
        w_div_ge = (w_trial >= {1'b0, r_div});
        w_diff   = r_quo - DW'(C_R_OFFSET);
        w_shift  = C_X_W'(r_den) << r_cnt;
        w_base   = 16'(C_COLD + C_STEP * int'(r_idx));
        w_sum    = w_base + 16'(r_q);
    end

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_idx   = r_idx;
        n_den   = r_den;
        n_x     = r_x;
        n_q     = r_q;
        n_temp  = r_temp;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_div = i_sample;
                    n_rem = '0;
                    n_quo = '0;
                    n_cnt = CW'(DW - 1);
                    if (i_sample == '0) begin
                        n_temp  = C_TEMP_W'(C_COLD);
                        n_state = L_DONE;
                    end else begin
                        n_state = L_DIV;
                    end
                end
            end
            // Restoring divide of the full-scale constant by the sample, one bit a cycle
            L_DIV: begin
                n_rem = w_div_ge ? (w_trial - {1'b0, r_div}) : w_trial;
                n_quo = {r_quo[DW-2:0], w_div_ge};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = L_RANGE;
                end
            end
            // Drop the series resistor and clamp at the table ends
            L_RANGE: begin
                n_idx = '0;
                if (r_quo < DW'(C_R_OFFSET)) begin
                    n_temp  = C_TEMP_W'(C_HOT);
                    n_state = L_DONE;
                end else if (w_diff >= DW'(res_at('0))) begin
                    n_temp  = C_TEMP_W'(C_COLD);
                    n_state = L_DONE;
                end else if (w_diff <= DW'(res_at(C_IDX_W'(C_NPOINTS - 1)))) begin
                    n_temp  = C_TEMP_W'(C_HOT);
                    n_state = L_DONE;
                end else begin
                    n_res   = C_RES_W'(w_diff);
                    n_state = L_SCAN;
                end
            end
            // Walk the table to the first segment holding the resistance
            L_SCAN: begin
                if (r_res >= res_at(r_idx + C_IDX_W'(1))) begin
                    n_state = L_SETUP;
                end else if (r_idx == C_IDX_W'(C_LAST_SEG)) begin
                    n_temp  = '0;
                    n_state = L_DONE;
                end else begin
                    n_idx = r_idx + C_IDX_W'(1);
                end
            end
            L_SETUP: begin
                n_den   = C_DEN_W'(res_at(r_idx) - res_at(r_idx + C_IDX_W'(1)));
                n_x     = C_X_W'(C_X_W'(C_STEP) * C_X_W'(res_at(r_idx) - r_res));
                n_q     = '0;
                n_cnt   = CW'(C_Q_W - 1);
                n_state = L_FRAC;
            end
            // Fraction of a step: quotient stays within nine bits
            L_FRAC: begin
                if (r_x >= w_shift) begin
                    n_x = r_x - w_shift;
                end
                n_q   = {r_q[C_Q_W-2:0], (r_x >= w_shift)};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = L_FIN;
                end
            end
            // Truncate toward zero: a negative result with a remainder rounds up
            L_FIN: begin
                if (w_sum < 0 && r_x != '0) begin
                    n_temp = C_TEMP_W'(w_sum + 16'sd1);
                end else begin
                    n_temp = C_TEMP_W'(w_sum);
                end
                n_state = L_DONE;
            end
            L_DONE: begin
                if (i_ack) begin
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        r_idx  <= n_idx;
        r_den  <= n_den;
        r_x    <= n_x;
        r_q    <= n_q;
        r_temp <= n_temp;
    end

    assign o_stat.busy = (r_state != L_IDLE);
    assign o_stat.done = (r_state == L_DONE);
    assign o_stat.temp = r_temp;

endmodule

// ----- hw/rtl/thtmp_merge.sv -----
`timescale 1ns / 1ps

module thtmp_merge
    import thtmp_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_lane_stat                  i_first,
    input  t_lane_stat                  i_second,
    input  logic                        i_stall,
    output logic                        o_ack,
    output logic                        o_valid,
    output logic signed [C_TEMP_W-1:0]  o_temp_first,
    output logic signed [C_TEMP_W-1:0]  o_temp_second
);

    logic                        r_valid;
    logic signed [C_TEMP_W-1:0]  r_temp_first;
    logic signed [C_TEMP_W-1:0]  r_temp_second;

    // Take both lanes once they finish and the output slot is free
    assign o_ack = i_first.done && i_second.done && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ack) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the beat while stalled
    always_ff @(posedge i_clk) begin
        if (o_ack) begin
            r_temp_first  <= i_first.temp;
            r_temp_second <= i_second.temp;
        end
    end

    assign o_valid       = r_valid;
    assign o_temp_first  = r_temp_first;
    assign o_temp_second = r_temp_second;

endmodule
